// File: rtl/vml_pkg.sv
// ----------------------------------------------------------------------------
// VU meter level/peak package
// Shared widths, constants, register codes and control types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package vml_pkg;

   // field and state widths
   localparam int SAMPLE_W = 10;
   localparam int GAIN_W   = 10;
   localparam int SCALED_W = 19;
   localparam int AVG_W    = 20;
   localparam int DCOUNT_W = 9;
   localparam int FILT_W   = 22;
   localparam int LEVEL_W  = 23;
   localparam int HOLD_W   = 16;
   localparam int LED_W    = 8;
   localparam int THRESH_W = 16;
   localparam int REF_W    = 3;
   localparam int CSR_W    = 3;

   // timing constants
   localparam int DECIMATE = 32;
   localparam int DEC_SH   = $clog2(DECIMATE);   // average divisor is a power of two
   localparam int HOLD_LEN = 4000;

   // front end
   localparam logic [SAMPLE_W-1:0] MIDSCALE = 10'd511;

   localparam logic [REF_W-1:0] REF_OFF    = 3'd0;
   localparam logic [REF_W-1:0] REF_0DBU   = 3'd1;
   localparam logic [REF_W-1:0] REF_4DBU   = 3'd2;
   localparam logic [REF_W-1:0] REF_12DBU  = 3'd3;
   localparam logic [REF_W-1:0] REF_20DBU  = 3'd4;

   localparam logic [GAIN_W-1:0] GAIN_OFF   = 10'd0;
   localparam logic [GAIN_W-1:0] GAIN_0DBU  = 10'd1000;
   localparam logic [GAIN_W-1:0] GAIN_4DBU  = 10'd631;
   localparam logic [GAIN_W-1:0] GAIN_12DBU = 10'd251;
   localparam logic [GAIN_W-1:0] GAIN_20DBU = 10'd100;

   // recursive filter
   localparam int COEF_OLDER = 93;
   localparam int COEF_OLD   = 218;
   localparam int FILT_SH    = 7;

   // LED thresholds, index = LED bit
   localparam logic [THRESH_W-1:0] LED_THRESH [LED_W] = '{
      16'd2660, 16'd4730, 16'd8412, 16'd13332,
      16'd18831, 16'd26600, 16'd37573, 16'd53074
   };

   // configuration register indexes
   typedef enum logic [0:0] {
      CSR_REF_LEVEL    = 1'b0,
      CSR_DISPLAY_MODE = 1'b1
   } csr_index_type;

   // load strobes into the level filter
   typedef struct packed {
      logic avg_load;    // average stage takes a beat
      logic filt_load;   // filter stage takes a beat
   } vml_filt_ctl_type;

endpackage

`default_nettype wire

// File: rtl/vml_if.sv
// ----------------------------------------------------------------------------
// VU meter level/peak stream interfaces
// Valid/ready channels for sample beats and result beats.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface vml_req_if;
   logic                          valid;
   logic                          ready;
   logic [vml_pkg::SAMPLE_W-1:0]  sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface vml_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [vml_pkg::LEVEL_W-1:0]  level;
   logic signed [vml_pkg::LEVEL_W-1:0]  peak;
   logic [vml_pkg::LED_W-1:0]           level_leds;
   logic [vml_pkg::LED_W-1:0]           peak_leds;

   modport source (output valid, output level, output peak, output level_leds,
                   output peak_leds, input ready);
   modport sink   (input valid, input level, input peak, input level_leds,
                   input peak_leds, output ready);
endinterface

`default_nettype wire

// File: rtl/vml_led_encode.sv
// ----------------------------------------------------------------------------
// VU meter LED encoder
// Maps a signed value onto eight thresholds as a dot or a bar pattern.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vml_led_encode (
   input  logic signed [vml_pkg::LEVEL_W-1:0] value,
   input  logic                               bar,
   output logic [vml_pkg::LED_W-1:0]          leds
);

   logic [vml_pkg::LED_W-1:0] hit;
   logic [vml_pkg::LED_W-1:0] hit_up;

   // thresholds rise with bit index, so hit is a thermometer code
   always_comb begin
      for (int k = 0; k < vml_pkg::LED_W; k++) begin
         hit[k] = !value[vml_pkg::LEVEL_W-1] &&
                  (value[vml_pkg::LEVEL_W-2:0] >=
                   (vml_pkg::LEVEL_W-1)'(vml_pkg::LED_THRESH[k]));
      end
   end

   // dot keeps only the top lit bit
   assign hit_up = {1'b0, hit[vml_pkg::LED_W-1:1]};
   assign leds   = bar ? hit : (hit & ~hit_up);

endmodule

`default_nettype wire

// File: rtl/vml_level_filter.sv
// ----------------------------------------------------------------------------
// VU meter level filter
// 31/32 running average, decimation counter and second-order level filter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vml_level_filter (
   input  logic                                clock,
   input  logic                                reset,
   input  vml_pkg::vml_filt_ctl_type           ctl,
   input  logic [vml_pkg::SCALED_W-1:0]        scaled,
   output logic signed [vml_pkg::LEVEL_W-1:0]  level
);

   localparam int ACC_W = vml_pkg::AVG_W + vml_pkg::DEC_SH + 1;
   localparam int NUM_W = 32;
   localparam int SUM_W = vml_pkg::FILT_W + 3;
   localparam int ROUND = (1 << vml_pkg::FILT_SH) - 1;

   logic [vml_pkg::AVG_W-1:0]           avg_ff, avg_in;
   logic [ACC_W-1:0]                    acc;
   logic [vml_pkg::DCOUNT_W-1:0]        dcount_ff, dcount_in;
   logic                                fire_ff, fire_in;
   logic signed [vml_pkg::FILT_W-1:0]   older_ff, old_ff, new_ff, new_in;
   logic signed [NUM_W-1:0]             p_older_ff, p_old_ff;
   logic signed [NUM_W-1:0]             num, num_adj, quo;
   logic signed [SUM_W-1:0]             lvl_sum;
   logic signed [vml_pkg::LEVEL_W-1:0]  level_ff, level_in;

   // running average: (avg * 31 + scaled) / 32
   always_comb begin
      acc    = (ACC_W'(avg_ff) << vml_pkg::DEC_SH) - ACC_W'(avg_ff) + ACC_W'(scaled);
      avg_in = acc[vml_pkg::DEC_SH +: vml_pkg::AVG_W];
   end

   // decimation countdown
   assign fire_in   = (dcount_ff == '0);
   assign dcount_in = fire_in ? vml_pkg::DCOUNT_W'(vml_pkg::DECIMATE)
                              : dcount_ff - 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         avg_ff    <= '0;
         dcount_ff <= vml_pkg::DCOUNT_W'(vml_pkg::DECIMATE);
         fire_ff   <= 1'b0;
      end else if (ctl.avg_load) begin
         avg_ff    <= avg_in;
         dcount_ff <= dcount_in;
         fire_ff   <= fire_in;
      end
   end

   // coefficient products are registered from the current states; fires are
   // far more than one beat apart, so they are settled before use
   always_ff @(posedge clock) begin
      if (reset) begin
         p_older_ff <= '0;
         p_old_ff   <= '0;
      end else begin
         p_older_ff <= NUM_W'(old_ff) * NUM_W'(vml_pkg::COEF_OLDER);
         p_old_ff   <= NUM_W'(new_ff) * NUM_W'(vml_pkg::COEF_OLD);
      end
   end

   // filter step, division by 128 truncates toward zero
   always_comb begin
      num     = $signed({{(NUM_W-vml_pkg::AVG_W){1'b0}}, avg_ff}) - p_older_ff + p_old_ff;
      num_adj = num[NUM_W-1] ? num + NUM_W'(ROUND) : num;
      quo     = num_adj >>> vml_pkg::FILT_SH;
      new_in  = quo[vml_pkg::FILT_W-1:0];
      lvl_sum = {{3{old_ff[vml_pkg::FILT_W-1]}}, old_ff}
              + {{3{new_in[vml_pkg::FILT_W-1]}}, new_in}
              + {{2{new_ff[vml_pkg::FILT_W-1]}}, new_ff, 1'b0};
      level_in = lvl_sum[vml_pkg::LEVEL_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         older_ff <= '0;
         old_ff   <= '0;
         new_ff   <= '0;
         level_ff <= '0;
      end else if (ctl.filt_load && fire_ff) begin
         older_ff <= old_ff;
         old_ff   <= new_ff;
         new_ff   <= new_in;
         level_ff <= level_in;
      end
   end

   assign level = level_ff;

`ifndef SYNTH
   a_dcount_range: assert property (@(posedge clock) disable iff (reset)
      dcount_ff <= vml_pkg::DCOUNT_W'(vml_pkg::DECIMATE))
      else $error("decimation count out of range");

   a_fire_reload: assert property (@(posedge clock) disable iff (reset)
      fire_ff |-> (dcount_ff == vml_pkg::DCOUNT_W'(vml_pkg::DECIMATE)))
      else $error("filter fire without counter reload");

   a_level_quiet: assert property (@(posedge clock) disable iff (reset)
      !(ctl.filt_load && fire_ff) |=> $stable(level_ff))
      else $error("level changed without a filter step");
`endif

endmodule

`default_nettype wire

// File: rtl/vu_meter_level_peak_unit.sv
// ----------------------------------------------------------------------------
// VU meter level/peak unit
// Rectify, scale, average and filter ADC samples; hold the peak; drive LEDs.
// Six-stage pipeline, one result per sample.
// One sample per cycle while the sink is ready; stages advance on own ready.
// Reset: synchronous, active high; clears valid, config, filter and peak state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vu_meter_level_peak_unit (
   input  logic                         clock,
   input  logic                         reset,
   vml_req_if.sink                      req_bus,
   vml_rsp_if.source                    rsp_bus,
   input  logic                         csr_wr_en,
   input  logic [0:0]                   csr_index,
   input  logic [vml_pkg::CSR_W-1:0]    csr_wr_data
);

   localparam int NSTG      = 6;
   localparam int STG_IN    = 0;
   localparam int STG_SCALE = 1;
   localparam int STG_AVG   = 2;
   localparam int STG_FILT  = 3;
   localparam int STG_PEAK  = 4;
   localparam int STG_OUT   = 5;

   logic [vml_pkg::REF_W-1:0]           ref_level_ff;
   logic                                display_mode_ff;

   logic [NSTG-1:0]                     vld_ff, vld_in, src, rdy, take;

   logic [vml_pkg::SAMPLE_W-1:0]        sample_ff, rect;
   logic [vml_pkg::GAIN_W-1:0]          gain;
   logic [vml_pkg::SAMPLE_W+vml_pkg::GAIN_W-1:0] prod;
   logic [vml_pkg::SCALED_W-1:0]        scaled_ff;

   vml_pkg::vml_filt_ctl_type           filt_ctl;
   logic signed [vml_pkg::LEVEL_W-1:0]  level;

   logic signed [vml_pkg::LEVEL_W-1:0]  lvl5_ff, peak_ff;
   logic [vml_pkg::HOLD_W-1:0]          hold_ff;
   logic                                hold_hit, peak_hit;

   logic [vml_pkg::LED_W-1:0]           lvl_leds, peak_leds;
   logic signed [vml_pkg::LEVEL_W-1:0]  out_level_ff, out_peak_ff;
   logic [vml_pkg::LED_W-1:0]           out_lvl_leds_ff, out_peak_leds_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ref_level_ff    <= vml_pkg::REF_OFF;
         display_mode_ff <= 1'b0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            vml_pkg::CSR_REF_LEVEL:    ref_level_ff    <= csr_wr_data[vml_pkg::REF_W-1:0];
            vml_pkg::CSR_DISPLAY_MODE: display_mode_ff <= csr_wr_data[0];
            default:                   ref_level_ff    <= ref_level_ff;
         endcase
      end
   end

   // pipeline flow control: a stage loads when it is empty or drains
   assign src = {vld_ff[NSTG-2:0], req_bus.valid};

   always_comb begin
      rdy[NSTG-1] = !vld_ff[NSTG-1] || rsp_bus.ready;
      for (int k = NSTG-2; k >= 0; k--) begin
         rdy[k] = !vld_ff[k] || rdy[k+1];
      end
      take = src & rdy;
      for (int k = 0; k < NSTG; k++) begin
         vld_in[k] = rdy[k] ? src[k] : vld_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_bus.ready = rdy[STG_IN];

   // input register
   always_ff @(posedge clock) begin
      if (take[STG_IN]) begin
         sample_ff <= req_bus.sample;
      end
   end

   // rectify about midscale and apply reference gain
   assign rect = (sample_ff >= vml_pkg::MIDSCALE) ? sample_ff - vml_pkg::MIDSCALE
                                                  : vml_pkg::MIDSCALE - sample_ff;

   always_comb begin
      unique case (ref_level_ff)
         vml_pkg::REF_OFF:   gain = vml_pkg::GAIN_OFF;
         vml_pkg::REF_4DBU:  gain = vml_pkg::GAIN_4DBU;
         vml_pkg::REF_12DBU: gain = vml_pkg::GAIN_12DBU;
         vml_pkg::REF_20DBU: gain = vml_pkg::GAIN_20DBU;
         default:            gain = vml_pkg::GAIN_0DBU;   // 0dBu and unused codes
      endcase
   end

   assign prod = rect * gain;

   always_ff @(posedge clock) begin
      if (take[STG_SCALE]) begin
         scaled_ff <= prod[vml_pkg::SCALED_W-1:0];
      end
   end

   // average and level filter
   assign filt_ctl.avg_load  = take[STG_AVG];
   assign filt_ctl.filt_load = take[STG_FILT];

   vml_level_filter u_filter (
      .clock  (clock),
      .reset  (reset),
      .ctl    (filt_ctl),
      .scaled (scaled_ff),
      .level  (level)
   );

   // peak hold
   assign hold_hit = (hold_ff == '0);
   assign peak_hit = hold_hit || (level > peak_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         peak_ff <= '0;
         hold_ff <= vml_pkg::HOLD_W'(vml_pkg::HOLD_LEN);
      end else if (take[STG_PEAK]) begin
         if (peak_hit) begin
            peak_ff <= level;
            hold_ff <= vml_pkg::HOLD_W'(vml_pkg::HOLD_LEN);
         end else begin
            hold_ff <= hold_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take[STG_PEAK]) begin
         lvl5_ff <= level;
      end
   end

   // LED patterns
   vml_led_encode u_lvl_leds (
      .value (lvl5_ff),
      .bar   (display_mode_ff),
      .leds  (lvl_leds)
   );

   vml_led_encode u_peak_leds (
      .value (peak_ff),
      .bar   (1'b0),
      .leds  (peak_leds)
   );

   // result register
   always_ff @(posedge clock) begin
      if (take[STG_OUT]) begin
         out_level_ff     <= lvl5_ff;
         out_peak_ff      <= peak_ff;
         out_lvl_leds_ff  <= lvl_leds;
         out_peak_leds_ff <= peak_leds;
      end
   end

   assign rsp_bus.valid      = vld_ff[STG_OUT];
   assign rsp_bus.level      = out_level_ff;
   assign rsp_bus.peak       = out_peak_ff;
   assign rsp_bus.level_leds = out_lvl_leds_ff;
   assign rsp_bus.peak_leds  = out_peak_leds_ff;

`ifndef SYNTH
   a_peak_covers_level: assert property (@(posedge clock) disable iff (reset)
      take[STG_PEAK] |=> (peak_ff >= lvl5_ff))
      else $error("held peak below current level");

   a_refresh_reload: assert property (@(posedge clock) disable iff (reset)
      take[STG_PEAK] && peak_hit |=> (hold_ff == vml_pkg::HOLD_W'(vml_pkg::HOLD_LEN)))
      else $error("peak refresh without hold reload");

   a_peak_stage_holds: assert property (@(posedge clock) disable iff (reset)
      vld_ff[STG_PEAK] && !rdy[STG_PEAK] |=>
         vld_ff[STG_PEAK] && $stable(lvl5_ff) && $stable(peak_ff))
      else $error("stalled peak stage lost its beat");
`endif

endmodule

`default_nettype wire

// File: tb/sv/vu_meter_level_peak_unit_test.sv
// ----------------------------------------------------------------------------
// VU meter level/peak unit testbench
// Streams ADC sample beats through the unit under random source and sink
// idling and predicts every result beat (level, peak and both LED patterns)
// with a cycle-free model of the rectifier, averager, decimated filter and
// peak hold. Register writes land only while the unit is drained. Covers
// every reference code, dot and bar mode, full-swing and quiet signals,
// and level decay after a loud burst.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vu_meter_level_peak_unit_test;

   typedef struct packed {
      logic signed [vml_pkg::LEVEL_W-1:0] level;
      logic signed [vml_pkg::LEVEL_W-1:0] peak;
      logic [vml_pkg::LED_W-1:0]          level_leds;
      logic [vml_pkg::LED_W-1:0]          peak_leds;
   } meter_beat_type;

   logic                         clock;
   logic                         reset;
   logic                         csr_wr_en;
   vml_pkg::csr_index_type       csr_index;
   logic [vml_pkg::CSR_W-1:0]    csr_wr_data;

   vml_req_if req_ch ();
   vml_rsp_if rsp_ch ();

   vu_meter_level_peak_unit uut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_ch),
      .rsp_bus     (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   // stimulus and expectation stores
   logic [vml_pkg::SAMPLE_W-1:0] sample_queue [$];
   meter_beat_type               level_expect [$];
   int unsigned                  queued_total;
   int unsigned                  checked_total;
   int unsigned                  error_count;

   // idling control
   int unsigned         tx_wait;
   int unsigned         rx_wait;
   bit                  tx_calm;
   bit                  rx_calm;
   bit                  rx_hold;

   // meter model: configuration and state
   logic [vml_pkg::REF_W-1:0]          ref_sel;
   bit                                 bar_mode;
   logic [vml_pkg::AVG_W-1:0]          avg_q;
   logic [vml_pkg::DCOUNT_W-1:0]       dcount_q;
   logic signed [vml_pkg::FILT_W-1:0]  f_older;
   logic signed [vml_pkg::FILT_W-1:0]  f_old;
   logic signed [vml_pkg::FILT_W-1:0]  f_new;
   logic signed [vml_pkg::LEVEL_W-1:0] lvl_q;
   logic signed [vml_pkg::LEVEL_W-1:0] pk_q;
   logic [vml_pkg::HOLD_W-1:0]         hold_q;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #1500000;
      $display("*** FAILED ***");
      $finish;
   end

   function automatic int unsigned pick_gap(input bit calm);
      return calm ? 0 : $urandom_range(0, 9);
   endfunction

   // first threshold reached from the top picks the lit bit
   function automatic logic [vml_pkg::LED_W-1:0] led_bits(
         input logic signed [vml_pkg::LEVEL_W-1:0] v, input bit bar);
      logic [vml_pkg::LED_W-1:0] pat;
      bit                        hit;
      pat = '0;
      hit = 1'b0;
      if (v >= 0) begin
         for (int k = vml_pkg::LED_W - 1; k >= 0; k--) begin
            if (!hit && int'(v) >= int'(vml_pkg::LED_THRESH[k])) begin
               hit = 1'b1;
               pat = bar ? vml_pkg::LED_W'((1 << (k + 1)) - 1) : vml_pkg::LED_W'(1 << k);
            end
         end
      end
      return pat;
   endfunction

   // one sample through rectifier, averager, decimated filter and peak hold
   task automatic advance_meter(input logic [vml_pkg::SAMPLE_W-1:0] s,
                                output meter_beat_type r);
      int unsigned rect;
      int unsigned gain;
      int unsigned acc;
      longint      num;
      longint      sum;
      bit          fire;
      rect = 32'((s >= vml_pkg::MIDSCALE) ? s - vml_pkg::MIDSCALE : vml_pkg::MIDSCALE - s);
      case (ref_sel)
         vml_pkg::REF_OFF:   gain = 32'(vml_pkg::GAIN_OFF);
         vml_pkg::REF_4DBU:  gain = 32'(vml_pkg::GAIN_4DBU);
         vml_pkg::REF_12DBU: gain = 32'(vml_pkg::GAIN_12DBU);
         vml_pkg::REF_20DBU: gain = 32'(vml_pkg::GAIN_20DBU);
         default:            gain = 32'(vml_pkg::GAIN_0DBU);   // unused codes fall back to 0dBu
      endcase
      acc   = avg_q * (vml_pkg::DECIMATE - 1) + rect * gain;
      avg_q = vml_pkg::AVG_W'(acc / vml_pkg::DECIMATE);

      fire     = (dcount_q == 0);
      dcount_q = dcount_q - 1'b1;
      if (fire) begin
         dcount_q = vml_pkg::DCOUNT_W'(vml_pkg::DECIMATE);
         f_older  = f_old;
         f_old    = f_new;
         num      = longint'(avg_q) - vml_pkg::COEF_OLDER * longint'(f_older)
                    + vml_pkg::COEF_OLD * longint'(f_old);
         // truncates toward zero, wraps
         f_new    = vml_pkg::FILT_W'(num / longint'(1 << vml_pkg::FILT_SH));
         sum      = longint'(f_older) + longint'(f_new) + 2 * longint'(f_old);
         lvl_q    = vml_pkg::LEVEL_W'(sum);
      end

      fire   = (hold_q == 0);
      hold_q = hold_q - 1'b1;
      if (fire || lvl_q > pk_q) begin
         pk_q   = lvl_q;
         hold_q = vml_pkg::HOLD_W'(vml_pkg::HOLD_LEN);
      end

      r.level      = lvl_q;
      r.peak       = pk_q;
      r.level_leds = led_bits(lvl_q, bar_mode);
      r.peak_leds  = led_bits(pk_q, 1'b0);
   endtask

   task automatic write_reg(input vml_pkg::csr_index_type idx,
                            input logic [vml_pkg::CSR_W-1:0] data);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      case (idx)
         vml_pkg::CSR_REF_LEVEL:    ref_sel  = data;
         vml_pkg::CSR_DISPLAY_MODE: bar_mode = data[0];
      endcase
   endtask

   task automatic queue_sample(input logic [vml_pkg::SAMPLE_W-1:0] s);
      sample_queue.push_back(s);
      queued_total++;
   endtask

   // every queued sample has produced its checked result beat
   task automatic wait_drained();
      while (checked_total != queued_total)
         @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // sample source: offers queued beats with per-item gaps
   always @(posedge clock) begin : sample_driver
      int unsigned    w;
      meter_beat_type beat;
      if (reset) begin
         req_ch.valid  <= 1'b0;
         req_ch.sample <= '0;
         tx_wait       <= 0;
         avg_q         = '0;
         dcount_q      = vml_pkg::DCOUNT_W'(vml_pkg::DECIMATE);
         f_older       = '0;
         f_old         = '0;
         f_new         = '0;
         lvl_q         = '0;
         pk_q          = '0;
         hold_q        = vml_pkg::HOLD_W'(vml_pkg::HOLD_LEN);
      end else begin
         w = tx_wait;
         if (req_ch.valid && req_ch.ready) begin
            advance_meter(req_ch.sample, beat);
            level_expect.push_back(beat);
            w = pick_gap(tx_calm);
         end
         // a beat on offer that was not taken stays as it is
         if (req_ch.ready || !req_ch.valid) begin
            if (w != 0) begin
               w = w - 1;
               req_ch.valid <= 1'b0;
            end else if (sample_queue.size() != 0) begin
               req_ch.valid  <= 1'b1;
               req_ch.sample <= sample_queue.pop_front();
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
         tx_wait <= w;
      end
   end

   // result sink: checks each beat against the oldest expectation
   always @(posedge clock) begin : result_monitor
      int unsigned    w;
      meter_beat_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         rx_wait      <= 0;
      end else begin
         w = rx_wait;
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (level_expect.size() == 0) begin
               $error("unexpected result beat: level %0d", rsp_ch.level);
               error_count++;
            end else begin
               want = level_expect.pop_front();
               if (rsp_ch.level !== want.level) begin
                  $error("level: expected %0d, actual %0d", want.level, rsp_ch.level);
                  error_count++;
               end
               if (rsp_ch.peak !== want.peak) begin
                  $error("peak: expected %0d, actual %0d", want.peak, rsp_ch.peak);
                  error_count++;
               end
               if (rsp_ch.level_leds !== want.level_leds) begin
                  $error("level_leds: expected %b, actual %b",
                         want.level_leds, rsp_ch.level_leds);
                  error_count++;
               end
               if (rsp_ch.peak_leds !== want.peak_leds) begin
                  $error("peak_leds: expected %b, actual %b",
                         want.peak_leds, rsp_ch.peak_leds);
                  error_count++;
               end
               checked_total++;
            end
            w = pick_gap(rx_calm);
         end else if (w != 0 && !rx_hold) begin
            w = w - 1;
         end
         rx_wait      <= w;
         rsp_ch.ready <= (w == 0) && !rx_hold;
      end
   end

   // stimulus sequence
   initial begin : stimulus
      int unsigned                  seg;
      int unsigned                  len;
      int unsigned                  amp;
      int unsigned                  random_sent;
      int                           v;
      bit                           noisy;
      logic [vml_pkg::REF_W-1:0]    ref_code;
      logic [vml_pkg::CSR_W-1:0]    mode_data;

      reset         = 1'b1;
      csr_wr_en     = 1'b0;
      csr_index     = vml_pkg::CSR_REF_LEVEL;
      csr_wr_data   = '0;
      ref_sel       = vml_pkg::REF_OFF;
      bar_mode      = 1'b0;
      tx_calm       = 1'b0;
      rx_calm       = 1'b0;
      rx_hold       = 1'b0;
      queued_total  = 0;
      checked_total = 0;
      error_count   = 0;
      random_sent   = 0;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes with the reference off, then at 0dBu in bar mode
      queue_sample(10'd0);
      queue_sample(10'd1023);
      queue_sample(10'd511);
      wait_drained();
      write_reg(vml_pkg::CSR_REF_LEVEL, vml_pkg::REF_0DBU);
      write_reg(vml_pkg::CSR_DISPLAY_MODE, 3'b111);
      queue_sample(10'd1023);
      queue_sample(10'd0);
      queue_sample(10'd512);
      queue_sample(10'd510);
      queue_sample(10'd511);
      queue_sample(10'd1);
      queue_sample(10'd1022);
      for (int i = 0; i < 15; i++)
         queue_sample({vml_pkg::SAMPLE_W{i[0]}});

      // loud burst, then a quiet tail while the level decays
      wait_drained();
      write_reg(vml_pkg::CSR_REF_LEVEL, vml_pkg::REF_0DBU);
      write_reg(vml_pkg::CSR_DISPLAY_MODE, 3'b000);
      for (int i = 0; i < 200; i++)
         queue_sample({vml_pkg::SAMPLE_W{i[0]}});
      for (int i = 0; i < 300; i++)
         queue_sample(vml_pkg::SAMPLE_W'(vml_pkg::MIDSCALE - 2 + $urandom_range(0, 4)));

      // random segments; the first eight sweep every reference code and mode
      seg = 0;
      while (seg < 8 || random_sent < 500) begin
         if (seg < 8 || $urandom_range(0, 2) != 0) begin
            wait_drained();
            if (seg < 8) begin
               ref_code  = vml_pkg::REF_W'(seg * 5);
               mode_data = vml_pkg::CSR_W'(seg * 3);
            end else begin
               ref_code  = vml_pkg::REF_W'($urandom_range(0, 7));
               mode_data = vml_pkg::CSR_W'($urandom_range(0, 7));
            end
            write_reg(vml_pkg::CSR_REF_LEVEL, ref_code);
            write_reg(vml_pkg::CSR_DISPLAY_MODE, mode_data);
            tx_calm <= ($urandom_range(0, 3) == 0);
            rx_calm <= ($urandom_range(0, 3) == 0);
         end

         len   = $urandom_range(40, 90);
         noisy = 1'b0;
         case ($urandom_range(0, 3))
            0:       amp = 512;                      // full swing
            1:       amp = $urandom_range(0, 512);
            2:       amp = $urandom_range(0, 8);     // quiet: decay and ringing
            default: noisy = 1'b1;
         endcase
         for (int i = 0; i < len; i++) begin
            if (noisy) begin
               v = $urandom_range(0, 1023);
            end else begin
               v = $urandom_range(0, amp);
               v = $urandom_range(0, 1) ? int'(vml_pkg::MIDSCALE) + v
                                        : int'(vml_pkg::MIDSCALE) - v;
               if (v < 0)
                  v = 0;
               if (v > 1023)
                  v = 1023;
            end
            queue_sample(vml_pkg::SAMPLE_W'(v));
         end
         random_sent += len;

         // sink holds off while the source keeps offering
         if (seg == 2 || $urandom_range(0, 9) == 0) begin
            @(posedge clock);
            rx_hold <= 1'b1;
            repeat (300) @(posedge clock);
            rx_hold <= 1'b0;
         end
         seg++;
      end

      wait_drained();
      repeat (20) @(posedge clock);
      if (level_expect.size() != 0) begin
         $error("%0d result beats never arrived", level_expect.size());
         error_count++;
      end
      if (error_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
